FILE: rtl/psp_pkg.sv
// shared types and constants of the pgm p5 stream parser
package psp_pkg;

  // default size limit of width and height, in bits
  localparam int PSP_DIM_BITS = 16;
  // depth of the queues between front, back and result ports
  localparam int PSP_QUEUE_DEPTH = 2;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_BAD_MAGIC      = 3'd0;
  localparam logic [2:0] ERR_WIDTH_MISSING  = 3'd1;
  localparam logic [2:0] ERR_WIDTH_BAD      = 3'd2;
  localparam logic [2:0] ERR_HEIGHT_MISSING = 3'd3;
  localparam logic [2:0] ERR_HEIGHT_BAD     = 3'd4;
  localparam logic [2:0] ERR_MAXVAL_MISSING = 3'd5;
  localparam logic [2:0] ERR_MAXVAL_BAD     = 3'd6;
  localparam logic [2:0] ERR_EARLY_END      = 3'd7;

  // one classified input item
  typedef struct packed {
    logic       eof;
    logic       ws;
    logic       hash;
    logic       newline;
    logic       digit;
    logic [3:0] digit_val;
    logic       is_p;
    logic       is_5;
    logic [7:0] data;
  } byte_class_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic [15:0] pixel_value;
    logic [2:0]  error_code;
    logic        last_of_frame;
  } result_t;

endpackage

FILE: rtl/psp_fifo.sv
// small register queue with push/full and pop/empty sides
module psp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/psp_front.sv
// front end: classifies each input item for the parser
module psp_front (
  input  logic                [7:0] data_byte,
  input  logic                      end_of_file,
  output psp_pkg::byte_class_t      cls
);
  import psp_pkg::*;

  logic [7:0] digit_off;

  assign digit_off = data_byte - 8'd48;

  // character classes
  always_comb begin
    cls.eof       = end_of_file;
    cls.ws        = (data_byte == 8'd32) || (data_byte >= 8'd9 && data_byte <= 8'd13);
    cls.hash      = (data_byte == 8'd35);
    cls.newline   = (data_byte == 8'd10);
    cls.digit     = (data_byte >= 8'd48) && (data_byte <= 8'd57);
    cls.digit_val = digit_off[3:0];
    cls.is_p      = (data_byte == 8'd80);
    cls.is_5      = (data_byte == 8'd53);
    cls.data      = data_byte;
  end

endmodule

FILE: rtl/psp_back.sv
// back end: header parser and pixel pairing, one item per cycle while the result queue has room
module psp_back #(
  parameter int DIM_BITS = psp_pkg::PSP_DIM_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  psp_pkg::byte_class_t in_cls,
  output logic                 in_ready,
  input  logic                 out_full,
  output logic                 out_valid,
  output psp_pkg::result_t     out_res
);
  import psp_pkg::*;

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXVAL = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [1:0] MM_NONE  = 2'd0;
  localparam logic [1:0] MM_P     = 2'd1;
  localparam logic [1:0] MM_P5    = 2'd2;
  localparam logic [1:0] MM_WRONG = 2'd3;

  localparam logic [16:0] NUM_SAT = 17'd65536;
  localparam logic [16:0] DIM_MAX = 17'((18'd1 << DIM_BITS) - 18'd1);

  logic [2:0]          phase, phase_next;
  logic                in_comment, in_comment_next;
  logic                tok, tok_next;
  logic [1:0]          magic, magic_next;
  logic [16:0]         num, num_next;
  logic                bad, bad_next;
  logic [DIM_BITS-1:0] held_w, held_w_next;
  logic [DIM_BITS-1:0] held_h, held_h_next;
  logic [7:0]          hi, hi_next;
  logic                have_hi, have_hi_next;
  logic [DIM_BITS-1:0] col, col_next;
  logic [DIM_BITS-1:0] row, row_next;

  logic                take;
  logic [20:0]         acc;
  logic [2:0]          fin_phase;
  logic                fin_emit;
  result_t             fin_res;
  logic [DIM_BITS-1:0] fin_w;
  logic [DIM_BITS-1:0] fin_h;
  logic [2:0]          eff_phase;
  logic [DIM_BITS:0]   col_inc;
  logic [DIM_BITS:0]   row_inc;

  assign in_ready = !out_full;
  assign take     = in_valid && in_ready;
  assign acc      = ({4'd0, num} << 3) + ({4'd0, num} << 1) + 21'(in_cls.digit_val);
  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;

  // result of ending the current token
  always_comb begin
    fin_phase = phase;
    fin_emit  = 1'b0;
    fin_res   = '0;
    fin_w     = held_w;
    fin_h     = held_h;
    unique case (phase)
      PH_MAGIC: begin
        if (magic != MM_P5) begin
          fin_emit           = 1'b1;
          fin_res.kind       = KIND_ERROR;
          fin_res.error_code = ERR_BAD_MAGIC;
          fin_phase          = PH_DONE;
        end else begin
          fin_phase = PH_WIDTH;
        end
      end
      PH_WIDTH: begin
        if (bad || num > DIM_MAX) begin
          fin_emit           = 1'b1;
          fin_res.kind       = KIND_ERROR;
          fin_res.error_code = ERR_WIDTH_BAD;
          fin_phase          = PH_DONE;
        end else begin
          fin_w     = num[DIM_BITS-1:0];
          fin_phase = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (bad || num > DIM_MAX) begin
          fin_emit           = 1'b1;
          fin_res.kind       = KIND_ERROR;
          fin_res.error_code = ERR_HEIGHT_BAD;
          fin_phase          = PH_DONE;
        end else begin
          fin_h     = num[DIM_BITS-1:0];
          fin_phase = PH_MAXVAL;
        end
      end
      default: begin
        fin_emit = 1'b1;
        if (bad || num == 17'd0 || num[16]) begin
          fin_res.kind       = KIND_ERROR;
          fin_res.error_code = ERR_MAXVAL_BAD;
          fin_phase          = PH_DONE;
        end else begin
          fin_res.kind         = KIND_HEADER;
          fin_res.image_width  = 16'(held_w);
          fin_res.image_height = 16'(held_h);
          fin_res.max_value    = num[15:0];
          if (held_w == '0 || held_h == '0) begin
            fin_res.last_of_frame = 1'b1;
            fin_phase             = PH_DONE;
          end else begin
            fin_phase = PH_PIXELS;
          end
        end
      end
    endcase
  end

  // per-item state update
  always_comb begin
    phase_next      = phase;
    in_comment_next = in_comment;
    tok_next        = tok;
    magic_next      = magic;
    num_next        = num;
    bad_next        = bad;
    held_w_next     = held_w;
    held_h_next     = held_h;
    hi_next         = hi;
    have_hi_next    = have_hi;
    col_next        = col;
    row_next        = row;
    out_valid       = 1'b0;
    out_res         = '0;
    eff_phase       = phase;
    if (take) begin
      if (in_cls.eof) begin
        // end of file: report unless the frame is already done, then rearm
        if (phase <= PH_MAXVAL && tok) begin
          eff_phase = fin_phase;
        end
        if (phase <= PH_MAXVAL && tok && fin_phase == PH_DONE) begin
          out_valid = 1'b1;
          out_res   = fin_res;
        end else begin
          out_res.kind = KIND_ERROR;
          unique case (eff_phase)
            PH_MAGIC: begin
              out_valid          = 1'b1;
              out_res.error_code = ERR_BAD_MAGIC;
            end
            PH_WIDTH: begin
              out_valid          = 1'b1;
              out_res.error_code = ERR_WIDTH_MISSING;
            end
            PH_HEIGHT: begin
              out_valid          = 1'b1;
              out_res.error_code = ERR_HEIGHT_MISSING;
            end
            PH_MAXVAL: begin
              out_valid          = 1'b1;
              out_res.error_code = ERR_MAXVAL_MISSING;
            end
            PH_PIXELS: begin
              out_valid          = 1'b1;
              out_res.error_code = ERR_EARLY_END;
            end
            default: begin
              out_res = '0;
            end
          endcase
        end
        phase_next      = PH_MAGIC;
        in_comment_next = 1'b0;
        tok_next        = 1'b0;
        magic_next      = MM_NONE;
        num_next        = '0;
        bad_next        = 1'b0;
        held_w_next     = '0;
        held_h_next     = '0;
        hi_next         = '0;
        have_hi_next    = 1'b0;
        col_next        = '0;
        row_next        = '0;
      end else if (phase == PH_PIXELS) begin
        // pair bytes into samples, high byte first
        if (!have_hi) begin
          hi_next      = in_cls.data;
          have_hi_next = 1'b1;
        end else begin
          have_hi_next        = 1'b0;
          out_valid           = 1'b1;
          out_res.kind        = KIND_PIXEL;
          out_res.pixel_value = {hi, in_cls.data};
          if (col_inc >= {1'b0, held_w}) begin
            col_next = '0;
            if (row_inc >= {1'b0, held_h}) begin
              out_res.last_of_frame = 1'b1;
              phase_next            = PH_DONE;
            end else begin
              row_next = row_inc[DIM_BITS-1:0];
            end
          end else begin
            col_next = col_inc[DIM_BITS-1:0];
          end
        end
      end else if (phase <= PH_MAXVAL) begin
        // header tokens, whitespace and comments
        if (in_comment) begin
          if (in_cls.newline) begin
            in_comment_next = 1'b0;
          end
        end else if (!tok && in_cls.ws) begin
          tok_next = 1'b0;
        end else if (!tok && in_cls.hash) begin
          in_comment_next = 1'b1;
        end else if (tok && in_cls.ws) begin
          tok_next    = 1'b0;
          magic_next  = MM_NONE;
          num_next    = '0;
          bad_next    = 1'b0;
          phase_next  = fin_phase;
          held_w_next = fin_w;
          held_h_next = fin_h;
          out_valid   = fin_emit;
          out_res     = fin_res;
          if (fin_phase == PH_PIXELS) begin
            col_next     = '0;
            row_next     = '0;
            have_hi_next = 1'b0;
          end
        end else begin
          // feed one character into the token
          tok_next = 1'b1;
          if (phase == PH_MAGIC) begin
            if (magic == MM_NONE && in_cls.is_p) begin
              magic_next = MM_P;
            end else if (magic == MM_P && in_cls.is_5) begin
              magic_next = MM_P5;
            end else begin
              magic_next = MM_WRONG;
            end
          end else if (in_cls.digit) begin
            if (acc > 21'd65535) begin
              num_next = NUM_SAT;
              bad_next = 1'b1;
            end else begin
              num_next = acc[16:0];
            end
          end else begin
            bad_next = 1'b1;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      in_comment <= 1'b0;
      tok        <= 1'b0;
      magic      <= MM_NONE;
      num        <= '0;
      bad        <= 1'b0;
      held_w     <= '0;
      held_h     <= '0;
      hi         <= '0;
      have_hi    <= 1'b0;
      col        <= '0;
      row        <= '0;
    end else begin
      phase      <= phase_next;
      in_comment <= in_comment_next;
      tok        <= tok_next;
      magic      <= magic_next;
      num        <= num_next;
      bad        <= bad_next;
      held_w     <= held_w_next;
      held_h     <= held_h_next;
      hi         <= hi_next;
      have_hi    <= have_hi_next;
      col        <= col_next;
      row        <= row_next;
    end
  end

endmodule

FILE: rtl/pgm_p5_stream_parser.sv
// top level of the pgm p5 stream parser
// Parses a 16-bit binary PGM (P5) file fed one byte per item, closed by an
// end-of-file item, and returns a header item, one item per big-endian pixel
// sample (the last one marked) or an error item. The block takes one item
// per clock cycle while the front queue has room: the front classifies each
// byte into a two-entry queue, the back parser updates its state once per
// item, and results leave through a two-entry output queue; a result is made
// from a byte held in the front queue and registered in the result queue
// before it can be popped. Input is held back only once a full result queue
// has stalled the back parser long enough to fill the front queue. width and
// height are limited to DIM_BITS bits; there is no clearing pass after reset.
module pgm_p5_stream_parser #(
  parameter int DIM_BITS = psp_pkg::PSP_DIM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [15:0] max_value,
  output logic [15:0] pixel_value,
  output logic [2:0]  error_code,
  output logic        last_of_frame
);
  import psp_pkg::*;

  localparam int CLS_BITS = $bits(byte_class_t);
  localparam int RES_BITS = $bits(result_t);

  byte_class_t         cls_in;
  byte_class_t         cls_q;
  logic [CLS_BITS-1:0] cls_bits;
  logic                cls_empty;
  logic                back_ready;
  result_t             back_res;
  logic                back_valid;
  logic                res_full;
  logic [RES_BITS-1:0] res_bits;
  result_t             res_q;

  // classify incoming items
  psp_front u_front (
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .cls         (cls_in)
  );

  // queue between front and back
  psp_fifo #(
    .WIDTH (CLS_BITS),
    .DEPTH (PSP_QUEUE_DEPTH)
  ) u_cls_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cls_in),
    .full    (full),
    .pop     (back_ready),
    .rd_data (cls_bits),
    .empty   (cls_empty)
  );

  assign cls_q = cls_bits;

  // parser
  psp_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!cls_empty),
    .in_cls    (cls_q),
    .in_ready  (back_ready),
    .out_full  (res_full),
    .out_valid (back_valid),
    .out_res   (back_res)
  );

  // result queue
  psp_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (PSP_QUEUE_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (back_valid),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  // result ports
  assign res_q         = res_bits;
  assign result_kind   = res_q.kind;
  assign image_width   = res_q.image_width;
  assign image_height  = res_q.image_height;
  assign max_value     = res_q.max_value;
  assign pixel_value   = res_q.pixel_value;
  assign error_code    = res_q.error_code;
  assign last_of_frame = res_q.last_of_frame;

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    back_valid |-> !res_full)
    else $error("result pushed into a full queue");

  a_item_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !cls_empty)
    else $error("accepted item missing from the front queue");

  a_last_not_error: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_frame) |-> (result_kind != KIND_ERROR))
    else $error("frame end marked on an error item");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_ERROR) |-> (pixel_value == '0 && max_value == '0))
    else $error("error item carries payload");

endmodule
